>>> hdl/positional_list_table_core_assert.svh
// assertion macros used by the positional list table datapath
`ifndef POSITIONAL_LIST_TABLE_CORE_ASSERT_SVH
`define POSITIONAL_LIST_TABLE_CORE_ASSERT_SVH

// same-cycle implication, disabled while reset is high
`define PLT_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("plt check failed");

// next-cycle implication, disabled while reset is high
`define PLT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("plt check failed");

`endif

>>> hdl/plt_pkg.sv
// shared types and constants of the positional list table
package plt_pkg;

   // default list capacity in records
   localparam int CAPACITY_DEFAULT = 128;

   // request kinds
   typedef enum logic [1:0] {
      KIND_READ   = 2'd0,
      KIND_LOCATE = 2'd1,
      KIND_INSERT = 2'd2,
      KIND_DELETE = 2'd3
   } kind_type;

   // controller states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RD_ISSUE,
      ST_RD_DATA,
      ST_SCAN,
      ST_INS_RD,
      ST_INS_WR,
      ST_DEL_RD,
      ST_DEL_WR,
      ST_DONE
   } state_type;

   // one stored record
   typedef struct packed {
      logic [63:0] tag;
      logic [31:0] price;
   } record_type;

   // controller to datapath
   typedef struct packed {
      logic req_ready;
      logic start;
      logic rd_en;
      logic rd_prev;
      logic wr_en;
      logic wr_prev;
      logic wr_new;
      logic idx_inc;
      logic idx_dec;
      logic cnt_inc;
      logic cnt_dec;
      logic res_err;
      logic res_ok;
      logic res_hit;
      logic emit;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic     req_valid;
      kind_type req_kind;
      logic     req_bad;
      logic     hit;
      logic     rd_valid;
      logic     idx_at_count;
      logic     idx_at_slot;
      logic     out_free;
   } sts_type;

endpackage

>>> hdl/plt_req_if.sv
// request channel: valid, ready and the request beat
interface plt_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [7:0]  position;
   logic [63:0] record_tag;
   logic [31:0] record_price;

   modport source (output valid, kind, position, record_tag, record_price, input ready);
   modport sink (input valid, kind, position, record_tag, record_price, output ready);
endinterface

>>> hdl/plt_rsp_if.sv
// response channel: valid, ready and the result beat
interface plt_rsp_if;
   logic        valid;
   logic        ready;
   logic        status;
   logic        found;
   logic [63:0] out_tag;
   logic [31:0] out_price;
   logic [7:0]  list_length;

   modport source (output valid, status, found, out_tag, out_price, list_length, input ready);
   modport sink (input valid, status, found, out_tag, out_price, list_length, output ready);
endinterface

>>> hdl/plt_ctrl.sv
// controller state machine of the positional list table
module plt_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  plt_pkg::sts_type sts,
   output plt_pkg::cmd_type cmd
);

   plt_pkg::state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= plt_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         plt_pkg::ST_IDLE: begin
            if (sts.req_valid) begin
               if (sts.req_bad) begin
                  state_in = plt_pkg::ST_DONE;
               end else begin
                  unique case (sts.req_kind)
                     plt_pkg::KIND_READ:   state_in = plt_pkg::ST_RD_ISSUE;
                     plt_pkg::KIND_LOCATE: state_in = plt_pkg::ST_SCAN;
                     plt_pkg::KIND_INSERT: state_in = plt_pkg::ST_INS_RD;
                     plt_pkg::KIND_DELETE: state_in = plt_pkg::ST_DEL_RD;
                     default:              state_in = plt_pkg::ST_IDLE;
                  endcase
               end
            end
         end
         plt_pkg::ST_RD_ISSUE: state_in = plt_pkg::ST_RD_DATA;
         plt_pkg::ST_RD_DATA:  state_in = plt_pkg::ST_DONE;
         plt_pkg::ST_SCAN: begin
            if (sts.hit || (sts.idx_at_count && !sts.rd_valid)) begin
               state_in = plt_pkg::ST_DONE;
            end
         end
         plt_pkg::ST_INS_RD: begin
            state_in = sts.idx_at_slot ? plt_pkg::ST_DONE : plt_pkg::ST_INS_WR;
         end
         plt_pkg::ST_INS_WR: state_in = plt_pkg::ST_INS_RD;
         plt_pkg::ST_DEL_RD: begin
            state_in = sts.idx_at_count ? plt_pkg::ST_DONE : plt_pkg::ST_DEL_WR;
         end
         plt_pkg::ST_DEL_WR: state_in = plt_pkg::ST_DEL_RD;
         plt_pkg::ST_DONE: begin
            if (sts.out_free) begin
               state_in = plt_pkg::ST_IDLE;
            end
         end
         default: state_in = plt_pkg::ST_IDLE;
      endcase
   end

   // command outputs
   always_comb begin
      cmd = '0;
      unique case (state_ff)
         plt_pkg::ST_IDLE: begin
            cmd.req_ready = 1'b1;
            cmd.start     = sts.req_valid;
            cmd.res_err   = sts.req_valid && sts.req_bad;
         end
         plt_pkg::ST_RD_ISSUE: cmd.rd_en = 1'b1;
         plt_pkg::ST_RD_DATA:  cmd.res_hit = 1'b1;
         plt_pkg::ST_SCAN: begin
            if (sts.hit) begin
               cmd.res_hit = 1'b1;
            end else if (!sts.idx_at_count) begin
               cmd.rd_en   = 1'b1;
               cmd.idx_inc = 1'b1;
            end else if (!sts.rd_valid) begin
               cmd.res_ok = 1'b1;
            end
         end
         plt_pkg::ST_INS_RD: begin
            if (sts.idx_at_slot) begin
               cmd.wr_en   = 1'b1;
               cmd.wr_new  = 1'b1;
               cmd.cnt_inc = 1'b1;
               cmd.res_ok  = 1'b1;
            end else begin
               cmd.rd_en   = 1'b1;
               cmd.rd_prev = 1'b1;
            end
         end
         plt_pkg::ST_INS_WR: begin
            cmd.wr_en   = 1'b1;
            cmd.idx_dec = 1'b1;
         end
         plt_pkg::ST_DEL_RD: begin
            if (sts.idx_at_count) begin
               cmd.cnt_dec = 1'b1;
               cmd.res_ok  = 1'b1;
            end else begin
               cmd.rd_en = 1'b1;
            end
         end
         plt_pkg::ST_DEL_WR: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_prev = 1'b1;
            cmd.idx_inc = 1'b1;
         end
         plt_pkg::ST_DONE: cmd.emit = sts.out_free;
         default: cmd = '0;
      endcase
   end

endmodule

>>> hdl/plt_datapath.sv
// datapath of the positional list table: record memory, index, count, result registers
`include "positional_list_table_core_assert.svh"

module plt_datapath #(
   parameter int CAPACITY = plt_pkg::CAPACITY_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   plt_req_if.sink          req_ch,
   plt_rsp_if.source        rsp_ch,
   input  plt_pkg::cmd_type cmd,
   output plt_pkg::sts_type sts
);

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int AW = $clog2(CAPACITY);
   localparam int XW = CW + 9;

   plt_pkg::record_type mem [CAPACITY];
   plt_pkg::record_type rdata_ff;
   plt_pkg::record_type wr_data;
   logic                rd_valid_ff;
   logic [AW-1:0]       rd_addr, wr_addr;

   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [CW-1:0] idx_m1;
   logic [7:0]    pos_ff;
   logic [63:0]   tag_ff;
   logic [31:0]   key_ff;

   logic [XW-1:0]     pos_x, cnt_x;
   logic              rd_bad, ins_bad;
   logic              req_bad;
   plt_pkg::kind_type req_kind;

   logic        pend_status_ff, pend_found_ff;
   logic [63:0] pend_tag_ff;
   logic [31:0] pend_price_ff;

   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_status_ff, rsp_found_ff;
   logic [63:0] rsp_tag_ff;
   logic [31:0] rsp_price_ff;
   logic [7:0]  rsp_len_ff;
   logic [CW+7:0] count_wide;

   // request checks against the current length
   assign req_kind = plt_pkg::kind_type'(req_ch.kind);
   assign pos_x    = XW'(req_ch.position);
   assign cnt_x    = XW'(count_ff);
   assign rd_bad   = (pos_x == '0) || (pos_x > cnt_x);
   assign ins_bad  = (pos_x == '0) || (pos_x > cnt_x + XW'(1)) || (cnt_x == XW'(CAPACITY));

   always_comb begin
      case (req_kind) inside
         plt_pkg::KIND_INSERT:                     req_bad = ins_bad;
         plt_pkg::KIND_READ, plt_pkg::KIND_DELETE: req_bad = rd_bad;
         default:                                  req_bad = 1'b0;
      endcase
   end

   assign req_ch.ready     = cmd.req_ready;
   assign sts.req_valid    = req_ch.valid;
   assign sts.req_kind     = req_kind;
   assign sts.req_bad      = req_bad;
   assign sts.hit          = rd_valid_ff && (rdata_ff.price == key_ff);
   assign sts.rd_valid     = rd_valid_ff;
   assign sts.idx_at_count = (idx_ff == count_ff);
   assign sts.idx_at_slot  = ((XW'(idx_ff) + XW'(1)) == XW'(pos_ff));
   assign sts.out_free     = !rsp_valid_ff || rsp_ch.ready;

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         pos_ff <= req_ch.position;
         tag_ff <= req_ch.record_tag;
         key_ff <= req_ch.record_price;
      end
   end

   // walking index: start point depends on the kind of request
   always_comb begin
      idx_in = idx_ff;
      if (cmd.start) begin
         case (req_kind)
            plt_pkg::KIND_READ:   idx_in = CW'(pos_x - XW'(1));
            plt_pkg::KIND_LOCATE: idx_in = '0;
            plt_pkg::KIND_INSERT: idx_in = count_ff;
            default:              idx_in = CW'(pos_x);
         endcase
      end else if (cmd.idx_inc) begin
         idx_in = idx_ff + CW'(1);
      end else if (cmd.idx_dec) begin
         idx_in = idx_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
   end

   // record count
   always_comb begin
      count_in = count_ff;
      if (cmd.cnt_inc) begin
         count_in = count_ff + CW'(1);
      end else if (cmd.cnt_dec) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // record memory, one write and one registered read per cycle
   assign idx_m1  = idx_ff - CW'(1);
   assign rd_addr = cmd.rd_prev ? idx_m1[AW-1:0] : idx_ff[AW-1:0];
   assign wr_addr = cmd.wr_prev ? idx_m1[AW-1:0] : idx_ff[AW-1:0];
   assign wr_data = cmd.wr_new ? plt_pkg::record_type'({tag_ff, key_ff}) : rdata_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= cmd.rd_en;
      end
   end

   // pending result of the request in work
   always_ff @(posedge clock) begin
      if (cmd.res_err || cmd.res_ok) begin
         pend_status_ff <= cmd.res_err;
         pend_found_ff  <= 1'b0;
         pend_tag_ff    <= '0;
         pend_price_ff  <= '0;
      end else if (cmd.res_hit) begin
         pend_status_ff <= 1'b0;
         pend_found_ff  <= 1'b1;
         pend_tag_ff    <= rdata_ff.tag;
         pend_price_ff  <= rdata_ff.price;
      end
   end

   // response output register
   assign count_wide = {8'd0, count_ff};

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_status_ff <= pend_status_ff;
         rsp_found_ff  <= pend_found_ff;
         rsp_tag_ff    <= pend_tag_ff;
         rsp_price_ff  <= pend_price_ff;
         rsp_len_ff    <= count_wide[7:0];
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.status      = rsp_status_ff;
   assign rsp_ch.found       = rsp_found_ff;
   assign rsp_ch.out_tag     = rsp_tag_ff;
   assign rsp_ch.out_price   = rsp_price_ff;
   assign rsp_ch.list_length = rsp_len_ff;

   // checks
   `PLT_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(CAPACITY))
   `PLT_ASSERT_NOW(a_insert_room, clock, reset, cmd.cnt_inc, count_ff != CW'(CAPACITY))
   `PLT_ASSERT_NOW(a_write_in_list, clock, reset, cmd.wr_en, idx_ff <= count_ff)
   `PLT_ASSERT_NOW(a_emit_free, clock, reset, cmd.emit, sts.out_free)
   `PLT_ASSERT_NEXT(a_delete_count, clock, reset, cmd.cnt_dec, count_ff == $past(count_ff) - CW'(1))

endmodule

>>> hdl/positional_list_table_core.sv
// an error skips the memory; a read fetches the record at the position; a locate compares
// records from the first until a price matches or the list ends; insert and delete shift the
// records from the position on by one, each a read then a write; insert then writes the new one
// one request is worked at a time; the next is taken once the result sits in the output register
// reset clears the length and the control state; the record memory is not cleared
// top level of the positional list table
module positional_list_table_core #(
   parameter int CAPACITY = plt_pkg::CAPACITY_DEFAULT
) (
   input logic       clock,
   input logic       reset,
   plt_req_if.sink   req_ch,
   plt_rsp_if.source rsp_ch
);

   plt_pkg::cmd_type cmd;
   plt_pkg::sts_type sts;

   // sequencing of memory walks
   plt_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .sts   (sts),
      .cmd   (cmd)
   );

   // storage and result path
   plt_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .cmd    (cmd),
      .sts    (sts)
   );

endmodule
